### sv/haversine_distance_core_defines.svh
// assertion macros for the haversine distance core
// used by haversine_distance_core.sv, no other dependencies
`ifndef HAVERSINE_DISTANCE_CORE_DEFINES_SVH
`define HAVERSINE_DISTANCE_CORE_DEFINES_SVH

// clocked implication checked outside reset
`define HD_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// clocked next-cycle implication checked outside reset
`define HD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/hav_pkg.sv
// package for the haversine distance core: widths, fixed-point constants, arctangent table
// no dependencies
`default_nettype none
package hav_pkg;

	localparam int LatW  = 31;
	localparam int LonW  = 32;
	localparam int DistW = 35;
	localparam int CordicStagesDef = 32;

	// angle and cordic datapath width (q30 values with sign and growth)
	localparam int AngW = 36;
	localparam int AccW = 66;

	localparam logic signed [AngW-1:0] DegQ      = 36'sd2012227627;
	localparam logic signed [AngW-1:0] PiQ30     = 36'sd3373259426;
	localparam logic signed [AngW-1:0] HalfPiQ30 = 36'sd1686629713;
	localparam logic signed [AngW-1:0] KQ30      = 36'sd652032874;
	localparam logic [61:0] OneQ60 = 62'h1000_0000_0000_0000;
	localparam logic [33:0] RMm    = 34'd6372797561;

	typedef logic signed [AngW-1:0] ang_t;

	// arctangent of stage i in q30
	function automatic ang_t atan_stage(input int i);
		ang_t r;
		r = '0;
		case (i)
			0: r = 36'sd843314857;
			1: r = 36'sd497837829;
			2: r = 36'sd263043837;
			3: r = 36'sd133525159;
			4: r = 36'sd67021687;
			5: r = 36'sd33543516;
			6: r = 36'sd16775851;
			7: r = 36'sd8388437;
			8: r = 36'sd4194283;
			9: r = 36'sd2097149;
			default: begin
				if (i <= 30) r = ang_t'(36'sd1 <<< (30 - i));
				else r = '0;
			end
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

### sv/haversine_distance_core.sv
// haversine distance core: pipelined fixed-point great-circle distance
// one request per cycle while the output is not stalled (global stall)
// reset clears only the valid bits; payload registers are not reset
// depends on hav_pkg and haversine_distance_core_defines.svh
`default_nettype none
`include "haversine_distance_core_defines.svh"
module haversine_distance_core #(
	parameter int CORDIC_STAGES = hav_pkg::CordicStagesDef
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic signed [hav_pkg::LatW-1:0]    lat_a,
	input  wire logic signed [hav_pkg::LonW-1:0]    lon_a,
	input  wire logic signed [hav_pkg::LatW-1:0]    lat_b,
	input  wire logic signed [hav_pkg::LonW-1:0]    lon_b,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic [hav_pkg::DistW-1:0]               distance_mm
);
	import hav_pkg::*;

	localparam int N  = CORDIC_STAGES;
	localparam int SQ = 31;   // square root digit stages

	// global pipeline advance: hold everything while the output is stalled
	logic adv;
	assign adv = !(out_valid && out_stall);
	assign in_stall = !adv;

	// stage 1: register inputs and differences
	logic v_s1;
	logic signed [32:0] la_s1, lb_s1, dlat_s1, dlon_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			la_s1   <= 33'(lat_a);
			lb_s1   <= 33'(lat_b);
			dlat_s1 <= 33'(lat_b) - 33'(lat_a);
			dlon_s1 <= 33'(lon_b) - 33'(lon_a);
		end
	end

	// stage 2: scale to q30 radians (differences halved); range reduction follows combinationally
	function automatic logic signed [AngW-1:0] to_rad(input logic signed [32:0] v,
		input logic half);
		logic signed [68:0] p;
		p = 69'(v) * 69'(DegQ);
		if (half) p = (p + (69'sd1 <<< 30)) >>> 31;
		else p = (p + (69'sd1 <<< 29)) >>> 30;
		return p[AngW-1:0];
	endfunction

	logic v_s2;
	ang_t th_s2 [4];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			th_s2[0] <= to_rad(la_s1, 1'b0);
			th_s2[1] <= to_rad(lb_s1, 1'b0);
			th_s2[2] <= to_rad(dlat_s1, 1'b1);
			th_s2[3] <= to_rad(dlon_s1, 1'b1);
		end
	end

	// rotation cordic, four lanes, one stage per register
	logic        rv  [N+1];
	ang_t        rx  [N+1][4];
	ang_t        ry  [N+1][4];
	ang_t        rz  [N+1][4];
	logic        rn  [N+1][4];
	always_comb begin
		rv[0] = v_s2;
		for (int l = 0; l < 4; l++) begin
			rx[0][l] = KQ30;
			ry[0][l] = '0;
			rn[0][l] = 1'b0;
			rz[0][l] = th_s2[l];
			if (th_s2[l] > HalfPiQ30) begin
				rz[0][l] = th_s2[l] - PiQ30;
				rn[0][l] = 1'b1;
			end else if (th_s2[l] < -HalfPiQ30) begin
				rz[0][l] = th_s2[l] + PiQ30;
				rn[0][l] = 1'b1;
			end
		end
	end
	for (genvar i = 0; i < N; i++) begin : g_rot
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) rv[i+1] <= 1'b0;
			else if (adv) rv[i+1] <= rv[i];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				for (int l = 0; l < 4; l++) begin
					rn[i+1][l] <= rn[i][l];
					if (rz[i][l] >= 0) begin
						rx[i+1][l] <= rx[i][l] - (ry[i][l] >>> i);
						ry[i+1][l] <= ry[i][l] + (rx[i][l] >>> i);
						rz[i+1][l] <= rz[i][l] - atan_stage(i);
					end else begin
						rx[i+1][l] <= rx[i][l] + (ry[i][l] >>> i);
						ry[i+1][l] <= ry[i][l] - (rx[i][l] >>> i);
						rz[i+1][l] <= rz[i][l] + atan_stage(i);
					end
				end
			end
		end
	end

	// sign fix of cordic outputs
	ang_t c1, c2, s1, sd;
	always_comb begin
		c1 = rn[N][0] ? -rx[N][0] : rx[N][0];
		c2 = rn[N][1] ? -rx[N][1] : rx[N][1];
		s1 = rn[N][2] ? -ry[N][2] : ry[N][2];
		sd = rn[N][3] ? -ry[N][3] : ry[N][3];
	end

	// stage h1: cc = round(c1*c2), s1 squared
	logic v_h1;
	ang_t cc_h1, sd_h1;
	logic signed [AccW-1:0] ss_h1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_h1 <= 1'b0;
		else if (adv) v_h1 <= rv[N];
	end
	always_ff @(posedge clk) begin
		logic signed [AccW-1:0] p;
		if (adv) begin
			p = AccW'(c1) * AccW'(c2);
			cc_h1 <= AngW'((p + (AccW'(1) <<< 29)) >>> 30);
			ss_h1 <= AccW'(s1) * AccW'(s1);
			sd_h1 <= sd;
		end
	end

	// stage h2: t = round(cc*sd)
	logic v_h2;
	ang_t t_h2, sd_h2;
	logic signed [AccW-1:0] ss_h2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_h2 <= 1'b0;
		else if (adv) v_h2 <= v_h1;
	end
	always_ff @(posedge clk) begin
		logic signed [AccW-1:0] p;
		if (adv) begin
			p = AccW'(cc_h1) * AccW'(sd_h1);
			t_h2  <= AngW'((p + (AccW'(1) <<< 29)) >>> 30);
			ss_h2 <= ss_h1;
			sd_h2 <= sd_h1;
		end
	end

	// stage h3: a = s1^2 + t*sd, saturated to 0..1
	logic v_h3;
	logic [61:0] a_h3, na_h3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_h3 <= 1'b0;
		else if (adv) v_h3 <= v_h2;
	end
	always_ff @(posedge clk) begin
		logic signed [AccW-1:0] a;
		logic [61:0] s;
		if (adv) begin
			a = ss_h2 + AccW'(t_h2) * AccW'(sd_h2);
			if (a < 0) s = '0;
			else if (a > AccW'(OneQ60)) s = OneQ60;
			else s = a[61:0];
			a_h3  <= s;
			na_h3 <= OneQ60 - s;
		end
	end

	// square roots, one result bit per stage, two lanes
	logic        qv [SQ+1];
	logic [61:0] qr [SQ+1][2];
	logic [61:0] qo [SQ+1][2];
	always_comb begin
		qv[0] = v_h3;
		qr[0][0] = a_h3;
		qr[0][1] = na_h3;
		qo[0][0] = '0;
		qo[0][1] = '0;
	end
	for (genvar i = 0; i < SQ; i++) begin : g_sqrt
		localparam logic [61:0] Bit = 62'd1 << (60 - 2*i);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) qv[i+1] <= 1'b0;
			else if (adv) qv[i+1] <= qv[i];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				for (int l = 0; l < 2; l++) begin
					if (qr[i][l] >= qo[i][l] + Bit) begin
						qr[i+1][l] <= qr[i][l] - (qo[i][l] + Bit);
						qo[i+1][l] <= (qo[i][l] >> 1) + Bit;
					end else begin
						qr[i+1][l] <= qr[i][l];
						qo[i+1][l] <= qo[i][l] >> 1;
					end
				end
			end
		end
	end

	// vectoring cordic: y = sqrt(a), x = sqrt(1-a)
	logic vv [N+1];
	ang_t vx [N+1];
	ang_t vy [N+1];
	ang_t vz [N+1];
	always_comb begin
		vv[0] = qv[SQ];
		vy[0] = AngW'(qo[SQ][0]);
		vx[0] = AngW'(qo[SQ][1]);
		vz[0] = '0;
	end
	for (genvar i = 0; i < N; i++) begin : g_vec
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vv[i+1] <= 1'b0;
			else if (adv) vv[i+1] <= vv[i];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				if (vy[i] > 0) begin
					vx[i+1] <= vx[i] + (vy[i] >>> i);
					vy[i+1] <= vy[i] - (vx[i] >>> i);
					vz[i+1] <= vz[i] + atan_stage(i);
				end else if (vy[i] < 0) begin
					vx[i+1] <= vx[i] - (vy[i] >>> i);
					vy[i+1] <= vy[i] + (vx[i] >>> i);
					vz[i+1] <= vz[i] - atan_stage(i);
				end else begin
					vx[i+1] <= vx[i];
					vy[i+1] <= vy[i];
					vz[i+1] <= vz[i];
				end
			end
		end
	end

	// stage m1: clamp angle and multiply 2z by radius
	logic v_m1;
	logic [67:0] prod_m1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_m1 <= 1'b0;
		else if (adv) v_m1 <= vv[N];
	end
	always_ff @(posedge clk) begin
		logic [33:0] c;
		if (adv) begin
			c = (vz[N] < 0) ? '0 : {vz[N][32:0], 1'b0};
			prod_m1 <= 68'(c) * 68'(RMm);
		end
	end

	// output register: round and truncate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv) out_valid <= v_m1;
	end
	always_ff @(posedge clk) begin
		logic [67:0] r;
		if (adv) begin
			r = (prod_m1 + (68'd1 << 29)) >> 30;
			distance_mm <= r[DistW-1:0];
		end
	end

	// checks
	`HD_ASSERT_IMPL(a_stall_only_when_full, in_stall, out_valid && out_stall,
		"input stalled without a stalled output")
	`HD_ASSERT_NEXT(a_hold_valid, out_valid && out_stall, out_valid,
		"output valid dropped under stall")
	`HD_ASSERT_NEXT(a_hold_data, out_valid && out_stall, $stable(distance_mm),
		"output data changed under stall")
	`HD_ASSERT_NEXT(a_m1_to_out, v_m1 && !in_stall, out_valid,
		"last stage valid lost")

endmodule
`default_nettype wire
